### rtl/acp_pkg.sv
package acp_pkg;

	localparam int NAME_CHARS = 8;
	localparam int NAME_SLOTS = 6;
	localparam int BYTE_W     = 8;
	localparam int NAME_W     = 64;
	localparam int LEN_W      = 4;
	localparam int ACC_W      = 33;
	localparam int ACC_EXT_W  = ACC_W + 5;
	localparam int DIG_W      = 5;
	localparam int IDX_W      = 3;
	localparam int MANT_W     = 32;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_NAME_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_LAST  = 3'd6;

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

	localparam logic [DIG_W-1:0] DIG_MAX = 5'd31;

	localparam logic signed [ACC_EXT_W-1:0] ACC_MAX = 38'sd4294967295;
	localparam logic signed [ACC_EXT_W-1:0] ACC_MIN = -38'sd4294967296;

	localparam logic signed [ACC_W:0] MANT_MAX = 34'sd2147483647;
	localparam logic signed [ACC_W:0] MANT_MIN = -34'sd2147483648;

	// parse state frozen at the end-marked byte
	typedef struct packed {
		logic [NAME_W-1:0]       name_shift;
		logic [LEN_W-1:0]        name_length;
		logic signed [ACC_W-1:0] value_acc;
		logic                    negative;
		logic [DIG_W-1:0]        digits;
		logic                    overflow;
	} acp_snap_t;

	typedef logic [NAME_SLOTS-1:0][NAME_W-1:0] acp_names_t;

endpackage

### rtl/acp_in_if.sv
interface acp_in_if import acp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              end_of_message;

	modport source(output valid, output rx_byte, output end_of_message, input ready);
	modport sink(input valid, input rx_byte, input end_of_message, output ready);
endinterface

### rtl/acp_out_if.sv
interface acp_out_if import acp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic [IDX_W-1:0]         name_index;
	logic signed [MANT_W-1:0] mantissa;
	logic [DIG_W-1:0]         fraction_digits;
	logic                     saturated;

	modport source(output valid, output found, output name_index, output mantissa,
		output fraction_digits, output saturated, input ready);
	modport sink(input valid, input found, input name_index, input mantissa,
		input fraction_digits, input saturated, output ready);
endinterface

### rtl/acp_cfg_if.sv
interface acp_cfg_if import acp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [NAME_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/acp_parse.sv
module acp_parse import acp_pkg::*; #(
	parameter int NameChars = NAME_CHARS
) (
	input  logic      clk,
	input  logic      arst_n,
	acp_in_if.sink    cmd,
	input  logic      snap_ready,
	output logic      snap_valid,
	output acp_snap_t snap
);

	typedef enum logic [1:0] {PH_NAME, PH_VSTART, PH_DIGITS, PH_DONE} phase_t;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eom_s1;
	logic              step;

	phase_t                  phase_q, phase_d;
	logic [NAME_W-1:0]       name_q, name_d;
	logic [LEN_W-1:0]        len_q, len_d;
	logic signed [ACC_W-1:0] acc_q, acc_d;
	logic                    neg_q, neg_d;
	logic                    dot_q, dot_d;
	logic [DIG_W-1:0]        dig_q, dig_d;
	logic                    ovf_q, ovf_d;

	logic                        snap_valid_s2;
	acp_snap_t                   snap_s2;
	logic                        value_step;
	logic signed [ACC_EXT_W-1:0] acc_ext;
	logic signed [ACC_EXT_W-1:0] acc_new;

	assign step      = valid_s1 && (!snap_valid_s2 || snap_ready);
	assign cmd.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			byte_s1 <= cmd.rx_byte;
			eom_s1  <= cmd.end_of_message;
		end
	end

	// acc*10 + (byte - '0') as two shifts and an add
	assign acc_ext = ACC_EXT_W'(acc_q);
	assign acc_new = (acc_ext <<< 3) + (acc_ext <<< 1)
		+ $signed({{(ACC_EXT_W-BYTE_W){1'b0}}, byte_s1})
		- $signed({{(ACC_EXT_W-BYTE_W){1'b0}}, CH_ZERO});

	always_comb begin
		phase_d    = phase_q;
		name_d     = name_q;
		len_d      = len_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		dot_d      = dot_q;
		dig_d      = dig_q;
		ovf_d      = ovf_q;
		value_step = 1'b0;
		case (phase_q)
			PH_NAME: begin
				if (byte_s1 == CH_EQ || byte_s1 == CH_NUL) begin
					phase_d = PH_VSTART;
				end else if (len_q < LEN_W'(NameChars)) begin
					for (int k = 0; k < NameChars; k++) begin
						if (len_q == LEN_W'(k)) begin
							name_d[BYTE_W*k +: BYTE_W] = byte_s1;
						end
					end
					len_d = len_q + LEN_W'(1);
				end else begin
					// too long: never matches
					len_d = LEN_W'(NameChars + 1);
				end
			end
			PH_VSTART: begin
				phase_d = PH_DIGITS;
				if (byte_s1 == CH_MINUS) begin
					neg_d = 1'b1;
				end else begin
					value_step = 1'b1;
				end
			end
			PH_DIGITS: begin
				value_step = 1'b1;
			end
			default: begin
			end
		endcase

		if (value_step) begin
			if (byte_s1 == CH_HASH || byte_s1 == CH_NUL) begin
				phase_d = PH_DONE;
			end else if (byte_s1 == CH_DOT) begin
				dot_d = 1'b1;
				dig_d = '0;
			end else begin
				if (acc_new > ACC_MAX) begin
					acc_d = ACC_W'(ACC_MAX);
					ovf_d = 1'b1;
				end else if (acc_new < ACC_MIN) begin
					acc_d = ACC_W'(ACC_MIN);
					ovf_d = 1'b1;
				end else begin
					acc_d = ACC_W'(acc_new);
				end
				if (dot_q) begin
					if (dig_q < DIG_MAX) begin
						dig_d = dig_q + DIG_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME;
			name_q  <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			dot_q   <= 1'b0;
			dig_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (eom_s1) begin
				phase_q <= PH_NAME;
				name_q  <= '0;
				len_q   <= '0;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				dot_q   <= 1'b0;
				dig_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				name_q  <= name_d;
				len_q   <= len_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				dot_q   <= dot_d;
				dig_q   <= dig_d;
				ovf_q   <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (step && eom_s1) begin
			snap_valid_s2 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && eom_s1) begin
			snap_s2.name_shift  <= name_d;
			snap_s2.name_length <= len_d;
			snap_s2.value_acc   <= acc_d;
			snap_s2.negative    <= neg_d;
			snap_s2.digits      <= dig_d;
			snap_s2.overflow    <= ovf_d;
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

endmodule

### rtl/acp_result.sv
module acp_result import acp_pkg::*; #(
	parameter int NameChars = NAME_CHARS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             snap_valid,
	input  acp_snap_t        snap,
	output logic             snap_ready,
	input  acp_names_t       names,
	input  logic [CNT_W-1:0] name_count,
	acp_out_if.source        result
);

	logic advance;
	logic load;

	logic [CNT_W-1:0]         cnt;
	logic [NAME_W-1:0]        eff [NAME_SLOTS];
	logic                     alive;
	logic                     hit;
	logic [IDX_W-1:0]         idx;
	logic signed [ACC_W:0]    m_ext;
	logic signed [MANT_W-1:0] m_sat;
	logic                     sat;

	logic                     valid_q;
	logic                     found_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [MANT_W-1:0] mant_q;
	logic [DIG_W-1:0]         dig_q;
	logic                     sat_q;

	assign advance    = !valid_q || result.ready;
	assign load       = snap_valid && advance;
	assign snap_ready = advance;

	always_comb begin
		cnt = (name_count > CNT_W'(NAME_SLOTS)) ? CNT_W'(NAME_SLOTS) : name_count;
		hit = 1'b0;
		idx = '0;
		for (int i = 0; i < NAME_SLOTS; i++) begin
			// a stored name ends at its first zero byte
			eff[i] = '0;
			alive  = 1'b1;
			for (int k = 0; k < NameChars; k++) begin
				alive = alive && (names[i][BYTE_W*k +: BYTE_W] != CH_NUL);
				if (alive) begin
					eff[i][BYTE_W*k +: BYTE_W] = names[i][BYTE_W*k +: BYTE_W];
				end
			end
		end
		if (snap.name_length <= LEN_W'(NameChars)) begin
			for (int i = 0; i < NAME_SLOTS; i++) begin
				if (!hit && CNT_W'(i) < cnt && eff[i] == snap.name_shift) begin
					hit = 1'b1;
					idx = IDX_W'(i);
				end
			end
		end
	end

	always_comb begin
		m_ext = snap.negative ? -(ACC_W+1)'(snap.value_acc) : (ACC_W+1)'(snap.value_acc);
		sat   = snap.overflow;
		if (m_ext > MANT_MAX) begin
			m_sat = MANT_W'(MANT_MAX);
			sat   = 1'b1;
		end else if (m_ext < MANT_MIN) begin
			m_sat = MANT_W'(MANT_MIN);
			sat   = 1'b1;
		end else begin
			m_sat = MANT_W'(m_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q <= hit;
			idx_q   <= hit ? idx : '0;
			mant_q  <= hit ? m_sat : '0;
			dig_q   <= hit ? snap.digits : '0;
			sat_q   <= hit && sat;
		end
	end

	assign result.valid           = valid_q;
	assign result.found           = found_q;
	assign result.name_index      = idx_q;
	assign result.mantissa        = mant_q;
	assign result.fraction_digits = dig_q;
	assign result.saturated       = sat_q;

endmodule

### rtl/assignment_command_parser_top.sv
// channel   dir  handshake      payload
// cmd       in   valid/ready    rx_byte[7:0], end_of_message
// result    out  valid/ready    found, name_index[2:0], mantissa[31:0], fraction_digits[4:0],
//                               saturated
// cfg       in   valid/ready    index[2:0], data[63:0]  (always ready)
//
// One item per cycle while results are taken; an end-marked item passes the input register,
// then parse state update and snapshot, then name match and saturation into the output
// register, where its result sits until the result sink takes it.
// The parse state register updates once per item and is the only loop.
// Reset clears all parse state, the name registers and the valid flags.
// A stalled result holds the output register; the snapshot and input registers behind it
// keep taking items until both are full.
module assignment_command_parser_top import acp_pkg::*; #(
	parameter int NameChars = NAME_CHARS
) (
	input  logic      clk,
	input  logic      arst_n,
	acp_in_if.sink    cmd,
	acp_out_if.source result,
	acp_cfg_if.sink   cfg
);

	logic             snap_valid;
	logic             snap_ready;
	acp_snap_t        snap;
	acp_names_t       names_q;
	logic [CNT_W-1:0] name_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_count_q <= '0;
			names_q      <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_NAME_COUNT: begin
					name_count_q <= cfg.data[CNT_W-1:0];
				end
				default: begin
					if (cfg.index >= REG_NAME_FIRST && cfg.index <= REG_NAME_LAST) begin
						names_q[IDX_W'(cfg.index - REG_NAME_FIRST)] <= cfg.data;
					end
				end
			endcase
		end
	end

	acp_parse #(
		.NameChars(NameChars)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.snap_ready(snap_ready),
		.snap_valid(snap_valid),
		.snap      (snap)
	);

	acp_result #(
		.NameChars(NameChars)
	) u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_valid(snap_valid),
		.snap      (snap),
		.snap_ready(snap_ready),
		.names     (names_q),
		.name_count(name_count_q),
		.result    (result)
	);

endmodule
